// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL of the ridge enhancer.
// Both macros sample on clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HRE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HRE_ASSERT(lbl, prop, msg)
`define HRE_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/hre_pkg.sv =====
// ----------------------------------------------------------------------------
// hre_pkg
// Types and constants shared by the ridge enhancer front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none
package hre_pkg;
  localparam int RowLimit   = 2048;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam int COORD_W   = 11;
  localparam int DIFF_W    = 18;  // fxx-fyy and the corner sum
  localparam int TR_W      = 20;  // fxx+fyy
  localparam int Q_W       = 38;  // 4d^2 + s^2
  localparam int ROOT_W    = Q_W / 2;
  localparam int FifoDepth = 4;
  localparam int FIFO_AW   = 2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] corner;
    logic signed [TR_W-1:0]   trace;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic                     frame_end;
  } hre_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hre_fifo_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/hre_fifo.sv =====
// ----------------------------------------------------------------------------
// hre_fifo
// Short queue of classified stencil items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hre_fifo import hre_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire hre_item_t push_data_i,
  input  wire logic      pop_i,
  output hre_item_t      pop_data_o,
  output hre_fifo_stat_t stat_o
);
  hre_item_t mem_q [FifoDepth];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);

  `HRE_NEVER(a_no_overflow, push_i && stat_o.full && !pop_i, "push into full queue")
  `HRE_NEVER(a_no_underflow, pop_i && stat_o.empty, "pop from empty queue")
  `HRE_ASSERT(a_cnt_bound, cnt_q <= (FIFO_AW+1)'(FifoDepth), "queue count out of range")
endmodule
`default_nettype wire

// ===== hw/rtl/hre_front.sv =====
// ----------------------------------------------------------------------------
// hre_front
// Line store, tap window and raster counters; forms the stencil sums.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hre_front import hre_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_WS     = 8,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [15:0]           pixel_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire hre_fifo_stat_t        fifo_stat_i,
  output logic                       push_o,
  output hre_item_t                  push_data_o
);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int NW    = XW + 1;
  localparam int YW    = $clog2(RowLimit);
  localparam int MW    = YW + 1;
  localparam int WSW   = $clog2(MAX_WS + 1);
  localparam int SPW   = WSW + 1;
  localparam int SLW   = (MAX_WS > 1) ? $clog2(2 * MAX_WS) : 1;
  localparam int Taps  = 2 * MAX_WS + 1;
  localparam int TIW   = $clog2(Taps);
  localparam int Depth = 2 * MAX_WS * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam logic F_IDLE = 1'b0;
  localparam logic F_WORK = 1'b1;

  logic [3:0]  win_size_q;
  logic [11:0] image_width_q, image_height_q;
  logic [XW-1:0]  col_q;
  logic [YW-1:0]  row_q;
  logic [SLW-1:0] slot_q;
  logic state_q;

  logic [PIXEL_BITS-1:0] mem [Depth];
  logic [PIXEL_BITS-1:0] rd_top_q, rd_mid_q, pix_q;
  logic [PIXEL_BITS-1:0] wt_q [Taps];
  logic [PIXEL_BITS-1:0] wm_q [Taps];
  logic [PIXEL_BITS-1:0] wb_q [Taps];
  logic [AW-1:0] addr_cur_q;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic emit_q, fend_q;

  // Clamp the configuration into its working range.
  logic [WSW-1:0] ws;
  logic [SPW-1:0] span;
  logic [NW-1:0]  n;
  logic [MW-1:0]  m;
  always_comb begin
    if (win_size_q == '0) ws = WSW'(1);
    else if (32'(win_size_q) > 32'(MAX_WS)) ws = WSW'(MAX_WS);
    else ws = WSW'(win_size_q);
    span = {ws, 1'b0};
    if (image_width_q == '0) n = NW'(1);
    else if (32'(image_width_q) > 32'(MAX_WIDTH)) n = NW'(MAX_WIDTH);
    else n = NW'(image_width_q);
    if (image_height_q == '0) m = MW'(1);
    else if (32'(image_height_q) > 32'(RowLimit)) m = MW'(RowLimit);
    else m = MW'(image_height_q);
  end

  logic accept, last_col, last_row, emit, cfg_hit;
  logic [SLW:0] slot_mid_w;
  logic [AW-1:0] addr_cur, addr_mid;
  assign in_ready_o = (state_q == F_IDLE) && !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign last_col   = (NW'(col_q) + NW'(1)) >= n;
  assign last_row   = (MW'(row_q) + MW'(1)) >= m;
  assign emit       = (NW'(col_q) >= NW'(span)) && (MW'(row_q) >= MW'(span));
  assign cfg_hit    = cfg_valid_i && ((cfg_index_i == CFG_WIN_SIZE) ||
                      (cfg_index_i == CFG_IMAGE_WIDTH) || (cfg_index_i == CFG_IMAGE_HEIGHT));
  assign slot_mid_w = ((SLW+1)'(slot_q) >= (SLW+1)'(ws)) ? (SLW+1)'(slot_q) - (SLW+1)'(ws)
                                                        : (SLW+1)'(slot_q) + (SLW+1)'(ws);
  assign addr_cur   = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);
  assign addr_mid   = AW'(slot_mid_w) * AW'(MAX_WIDTH) + AW'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q     <= 4'd1;
      image_width_q  <= 12'd2048;
      image_height_q <= 12'd2048;
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
      state_q <= F_IDLE;
    end else begin
      if (cfg_hit) begin
        case (cfg_index_i)
          CFG_WIN_SIZE:     win_size_q     <= cfg_data_i[3:0];
          CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          default:          win_size_q     <= win_size_q;
        endcase
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + 1'b1;
            slot_q <= ((SPW'(slot_q) + SPW'(1)) >= span) ? '0 : slot_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      case (state_q)
        F_IDLE:  if (accept) state_q <= F_WORK;
        F_WORK:  state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Read both rows on accept, write the new pixel in the following cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_top_q   <= mem[addr_cur];
      rd_mid_q   <= mem[addr_mid];
      pix_q      <= pixel_i[PIXEL_BITS-1:0];
      addr_cur_q <= addr_cur;
      emit_q     <= emit;
      fend_q     <= last_col && last_row;
      ox_q       <= COORD_W'(32'(col_q) - 32'(ws));
      oy_q       <= COORD_W'(32'(row_q) - 32'(ws));
    end
    if (state_q == F_WORK) begin
      mem[addr_cur_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_WORK) begin
      wt_q[0] <= rd_top_q;
      wm_q[0] <= rd_mid_q;
      wb_q[0] <= pix_q;
      for (int k = 1; k < Taps; k++) begin
        wt_q[k] <= wt_q[k-1];
        wm_q[k] <= wm_q[k-1];
        wb_q[k] <= wb_q[k-1];
      end
    end
  end

  // Taps after the shift: center is old[ws-1], far edge is old[span-1].
  logic [TIW-1:0] ic, i2;
  logic signed [TR_W-1:0] t0, tc, t2, m0, mc, m2, b0, bc, b2;
  always_comb begin
    ic = TIW'(ws - 1'b1);
    i2 = TIW'(span - 1'b1);
    t0 = TR_W'(rd_top_q);
    m0 = TR_W'(rd_mid_q);
    b0 = TR_W'(pix_q);
    tc = TR_W'(wt_q[ic]);
    mc = TR_W'(wm_q[ic]);
    bc = TR_W'(wb_q[ic]);
    t2 = TR_W'(wt_q[i2]);
    m2 = TR_W'(wm_q[i2]);
    b2 = TR_W'(wb_q[i2]);
    push_data_o.diff      = DIFF_W'(m0 + m2 - bc - tc);
    push_data_o.corner    = DIFF_W'(b0 + t2 - b2 - t0);
    push_data_o.trace     = m0 + m2 + bc + tc - (mc <<< 2);
    push_data_o.x         = ox_q;
    push_data_o.y         = oy_q;
    push_data_o.frame_end = fend_q;
  end
  assign push_o = (state_q == F_WORK) && emit_q;

  `HRE_ASSERT(a_slot_range, (SPW'(slot_q) < span) || $past(cfg_hit), "row slot beyond span")
  `HRE_NEVER(a_work_push_space, push_o && $past(fifo_stat_i.full), "accepted with queue full")
  `HRE_NEVER(a_ready_in_work, in_ready_o && (state_q == F_WORK), "ready during store write")
endmodule
`default_nettype wire

// ===== hw/rtl/hre_back.sv =====
// ----------------------------------------------------------------------------
// hre_back
// Squares, digit-serial square root, min and saturation; output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hre_back import hre_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hre_fifo_stat_t fifo_stat_i,
  input  wire hre_item_t  pop_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [15:0]     enhanced_o,
  output logic [COORD_W-1:0] out_x_o,
  output logic [COORD_W-1:0] out_y_o,
  output logic            frame_end_o
);
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_SUM  = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;
  localparam int IW = $clog2(ROOT_W);

  logic [2:0] state_q;
  logic [IW-1:0] iter_q;
  hre_item_t item_q;
  logic [2*DIFF_W-1:0] dd_q, ss_q;
  logic [Q_W-1:0] q_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic out_valid_q;
  logic [15:0] enh_q;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic fend_q;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == B_IDLE) && !fifo_stat_i.empty;

  // One root digit per cycle.
  logic [ROOT_W+1:0] rem_sh, trial;
  logic [1:0] pair;
  always_comb begin
    pair   = q_q[Q_W-1 -: 2];
    rem_sh = {rem_q[ROOT_W-1:0], pair};
    trial  = {root_q, 2'b01};
  end

  // Final response.
  logic [TR_W-1:0] neg, half, resp;
  logic [15:0] sat;
  always_comb begin
    neg  = TR_W'(-item_q.trace);
    half = TR_W'(root_q >> 1);
    resp = (half < neg) ? half : neg;
    sat  = (resp > TR_W'(16'hFFFF)) ? 16'hFFFF : resp[15:0];
    if (!item_q.trace[TR_W-1]) sat = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == B_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: if (pop_o) state_q <= B_MUL;
        B_MUL:  state_q <= B_SUM;
        B_SUM: begin
          state_q <= B_ROOT;
          iter_q  <= IW'(ROOT_W - 1);
        end
        B_ROOT: begin
          if (iter_q == '0) state_q <= B_DONE;
          else iter_q <= iter_q - 1'b1;
        end
        B_DONE: begin
          if (out_free) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (pop_o) item_q <= pop_data_i;
      B_MUL: begin
        dd_q <= (2*DIFF_W)'(item_q.diff * item_q.diff);
        ss_q <= (2*DIFF_W)'(item_q.corner * item_q.corner);
      end
      B_SUM: begin
        q_q    <= Q_W'({dd_q, 2'b00}) + Q_W'(ss_q);
        rem_q  <= '0;
        root_q <= '0;
      end
      B_ROOT: begin
        q_q <= {q_q[Q_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      B_DONE: begin
        if (out_free) begin
          enh_q  <= sat;
          ox_q   <= item_q.x;
          oy_q   <= item_q.y;
          fend_q <= item_q.frame_end;
        end
      end
      default: item_q <= item_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign enhanced_o  = enh_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign frame_end_o = fend_q;

  `HRE_ASSERT(a_load_on_free, (state_q == B_DONE) && out_free |=> out_valid_q, "result not loaded")
  `HRE_NEVER(a_pop_only_idle, pop_o && (state_q != B_IDLE), "pop outside idle")
  `HRE_ASSERT(a_iter_range, iter_q <= IW'(ROOT_W - 1), "root step count out of range")
endmodule
`default_nettype wire

// ===== hw/rtl/hessian_ridge_enhance_2d.sv =====
// Path to result valid: the front reads the line store on input transfer, the
// item passes the queue; the back then squares, sums, takes the root, saturates.
// Flow: the front takes no new pixel while it writes the line store (memory
// read then write); the back takes no new item until its result is loaded.
// Reset: counters, queue and control clear; the line store is never cleared.
// ----------------------------------------------------------------------------
// hessian_ridge_enhance_2d
// Streaming 2-D Hessian ridge enhancer: a front forms the stencil sums from
// the line store, a queue decouples it from a back that does the squares,
// square root, min and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module hessian_ridge_enhance_2d import hre_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_WS     = 8,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [15:0]           pixel_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [15:0]                enhanced_o,
  output logic [COORD_W-1:0]         out_x_o,
  output logic [COORD_W-1:0]         out_y_o,
  output logic                       frame_end_o
);
  hre_fifo_stat_t fifo_stat;
  hre_item_t push_data, pop_data;
  logic push, pop;

  // User must write configuration only while idle; not enforced, always ready.
  assign cfg_ready_o = 1'b1;

  hre_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WS    (MAX_WS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .pixel_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .fifo_stat_i(fifo_stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // Hold stencil items here so front and back stall on their own.
  hre_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (fifo_stat)
  );

  hre_back u_back (
    .clk_i,
    .rst_ni,
    .fifo_stat_i(fifo_stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .enhanced_o,
    .out_x_o,
    .out_y_o,
    .frame_end_o
  );
endmodule
`default_nettype wire

// ===== tb/tb_hessian_ridge_enhance_2d.sv =====
// ----------------------------------------------------------------------------
// tb_hessian_ridge_enhance_2d
// Self-checking bench for the streaming Hessian ridge enhancer. Pixels are
// pushed frame by frame through the valid/ready input. A scoreboard holds its
// own copy of the line store and tap lines and computes each interior
// response. It compares every output transfer, field by field, against the
// oldest response it has computed. Random gaps, a long receiver hold-off and
// several register settings, extremes included, are used.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_hessian_ridge_enhance_2d;
  import hre_pkg::*;

  localparam int MaxWidth   = 2048;
  localparam int MaxWs      = 8;
  localparam int NumTaps    = 2 * MaxWs + 1;
  localparam int CycleLimit = 3000000;
  localparam int SettleCyc  = 40;   // margin for the pipe to settle after the last response
  localparam int HoldOffCyc = 400;
  localparam bit [CFG_IDX_W-1:0] CfgNoReg = 2'd3;

  typedef enum int {
    PIX_NOISE, PIX_DIM, PIX_RIDGE, PIX_RAILS, PIX_VLINE, PIX_FLAT_MAX, PIX_FLAT_ZERO
  } pix_mode_e;

  typedef struct {
    bit [15:0]        enhanced;
    bit [COORD_W-1:0] x;
    bit [COORD_W-1:0] y;
    bit               frame_end;
  } ridge_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: ridge predictor plus the queue of pending responses
  // --------------------------------------------------------------------------
  class ridge_scoreboard;
    bit [15:0]  rows[2 * MaxWs * MaxWidth];
    bit [15:0]  taps[3][NumTaps];
    int         col;
    int         row;
    bit [3:0]   spacing_reg;
    bit [11:0]  width_reg;
    bit [11:0]  height_reg;
    ridge_res_t pending[$];

    function new();
      col = 0;
      row = 0;
      spacing_reg = 4'd1;
      width_reg = 12'd2048;
      height_reg = 12'd2048;
    endfunction

    static function int clampi(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned one;
      root = 0;
      one = 64'd1 << 62;
      while (one > v) one >>= 2;
      while (one != 0) begin
        if (v >= root + one) begin
          v -= root + one;
          root = (root >> 1) + one;
        end else begin
          root >>= 1;
        end
        one >>= 2;
      end
      return root;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WIN_SIZE:     spacing_reg = data[3:0];
        CFG_IMAGE_WIDTH:  width_reg = data;
        CFG_IMAGE_HEIGHT: height_reg = data;
        default:          return;   // unmapped index: leave position alone
      endcase
      col = 0;
      row = 0;
    endfunction

    // Note one accepted pixel; queue a response when it completes a stencil.
    function void note_pixel(bit [15:0] pix);
      int ws, n, m, span, cur, mid;
      longint t0, tc, t2, m0, mc, m2, b0, bc, b2, fxx, fyy, s, tr, d;
      longint unsigned root, neg, resp;
      ridge_res_t r;
      ws = clampi(spacing_reg, 1, MaxWs);
      n = clampi(width_reg, 1, MaxWidth);
      m = clampi(height_reg, 1, RowLimit);
      span = 2 * ws;
      cur = row % span;
      mid = (row + span - ws) % span;
      for (int k = NumTaps - 1; k > 0; k--)
        for (int j = 0; j < 3; j++) taps[j][k] = taps[j][k-1];
      taps[0][0] = rows[cur * MaxWidth + col];
      taps[1][0] = rows[mid * MaxWidth + col];
      taps[2][0] = pix;
      rows[cur * MaxWidth + col] = pix;
      if (col >= span && row >= span) begin
        t0 = taps[0][0]; tc = taps[0][ws]; t2 = taps[0][span];
        m0 = taps[1][0]; mc = taps[1][ws]; m2 = taps[1][span];
        b0 = taps[2][0]; bc = taps[2][ws]; b2 = taps[2][span];
        fxx = m0 + m2 - 2 * mc;
        fyy = bc + tc - 2 * mc;
        s = b0 + t2 - b2 - t0;
        tr = fxx + fyy;
        resp = 0;
        if (tr < 0) begin
          d = fxx - fyy;
          root = int_sqrt(4 * d * d + s * s) >> 1;
          neg = -tr;
          resp = (root < neg) ? root : neg;
          if (resp > 65535) resp = 65535;
        end
        r.enhanced = resp[15:0];
        r.x = COORD_W'(col - ws);
        r.y = COORD_W'(row - ws);
        r.frame_end = (col + 1 >= n && row + 1 >= m);
        pending.push_back(r);
      end
      if (col + 1 >= n) begin
        col = 0;
        row = (row + 1 >= m) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    // Compare one output transfer with the oldest pending response.
    function string check_result(ridge_res_t got);
      ridge_res_t want;
      string msg;
      if (pending.size() == 0)
        return $sformatf("unexpected result x=%0d y=%0d enh=%0d", got.x, got.y, got.enhanced);
      want = pending.pop_front();
      msg = "";
      if (got.enhanced != want.enhanced)
        msg = {msg, $sformatf(" enhanced %0d/%0d", got.enhanced, want.enhanced)};
      if (got.x != want.x) msg = {msg, $sformatf(" x %0d/%0d", got.x, want.x)};
      if (got.y != want.y) msg = {msg, $sformatf(" y %0d/%0d", got.y, want.y)};
      if (got.frame_end != want.frame_end)
        msg = {msg, $sformatf(" frame_end %0d/%0d", got.frame_end, want.frame_end)};
      if (msg != "")
        msg = {$sformatf("at (%0d,%0d) got/want:", want.x, want.y), msg};
      return msg;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           pixel_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [15:0]           enhanced_o;
  logic [COORD_W-1:0]    out_x_o;
  logic [COORD_W-1:0]    out_y_o;
  logic                  frame_end_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  hessian_ridge_enhance_2d dut (.*);

  ridge_scoreboard sb = new();
  int  mismatches   = 0;
  int  pixels_sent  = 0;
  int  results_seen = 0;
  int  frames_run   = 0;
  int  cycles       = 0;
  bit  holdoff_req  = 1'b0;
  bit  receiver_on  = 1'b0;

  task automatic report_mismatch(string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  // Watchdog: end the run when the cycle budget is spent.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk_i) begin
    ridge_res_t got;
    string msg;
    if (rst_ni && in_valid_i && in_ready_o) sb.note_pixel(pixel_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.enhanced = enhanced_o;
      got.x = out_x_o;
      got.y = out_y_o;
      got.frame_end = frame_end_o;
      results_seen++;
      msg = sb.check_result(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Mostly no gap, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    wait (receiver_on);
    forever begin
      if (holdoff_req) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (HoldOffCyc) @(negedge clk_i);
        holdoff_req = 1'b0;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Offer one pixel after a random gap; keep valid high across back-to-back items.
  task automatic send_pixel(bit [15:0] pix, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  // Drop valid, wait for every pending response, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // Drop valid after each write before the next, so back-to-back writes stay apart.
  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(int ws, int w, int h);
    write_reg(CFG_WIN_SIZE, CFG_DATA_W'(ws));
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic bit [15:0] make_pixel(pix_mode_e mode, int x, int y, int lx, int ly);
    case (mode)
      PIX_DIM:       return 16'($urandom_range(0, 255));
      PIX_RIDGE:     return (x == lx || y == ly) ? 16'($urandom_range(40000, 65535))
                                                 : 16'($urandom_range(0, 3000));
      PIX_RAILS:     return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      PIX_VLINE:     return (x == 1) ? 16'hffff : 16'h0000;
      PIX_FLAT_MAX:  return 16'hffff;
      PIX_FLAT_ZERO: return 16'h0000;
      default:       return 16'($urandom());
    endcase
  endfunction

  // Stream count pixels in raster order over a w-pixel row.
  task automatic stream(pix_mode_e mode, int w, int count);
    int lx, ly;
    lx = $urandom_range(0, w - 1);
    ly = $urandom_range(0, 20);
    for (int i = 0; i < count; i++)
      send_pixel(make_pixel(mode, i % w, (i / w), lx, ly));
  endtask

  task automatic run_frames(int ws, int w, int h, int frames, pix_mode_e mode);
    set_geometry(ws, w, h);
    stream(mode, w, w * h * frames);
    frames_run += frames;
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int ws, w, h;
    pix_mode_e mode;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    receiver_on = 1'b1;
    @(negedge clk_i);

    // Directed: saturating vertical line, flat frames, pixel extremes.
    run_frames(1, 3, 3, 1, PIX_VLINE);
    run_frames(1, 3, 3, 1, PIX_FLAT_MAX);
    run_frames(1, 3, 3, 1, PIX_FLAT_ZERO);
    run_frames(1, 4, 4, 1, PIX_RAILS);
    // Spacing 0 acts as 1; spacing above the maximum acts as the maximum.
    run_frames(0, 5, 4, 1, PIX_NOISE);
    run_frames(15, 17, 17, 1, PIX_RIDGE);
    // Image too small for the stencil: no results, counters still wrap.
    run_frames(2, 4, 9, 1, PIX_NOISE);
    run_frames(3, 0, 0, 1, PIX_NOISE);
    set_geometry(1, 0, 5);
    stream(PIX_NOISE, 1, 12);
    drain();
    // Oversized width clamps to the maximum; a short partial first row.
    set_geometry(1, 4095, 4095);
    stream(PIX_DIM, MaxWidth, 40);
    drain();
    // Oversized height with a narrow row; partial frame with results.
    set_geometry(1, 3, 4095);
    stream(PIX_NOISE, 3, 60);
    drain();
    // An unmapped register write in the middle of a frame.
    set_geometry(1, 5, 6);
    stream(PIX_NOISE, 5, 13);
    drain();
    write_reg(CfgNoReg, 12'hfff);
    stream(PIX_NOISE, 5, 17 + 30);
    frames_run += 2;
    drain();

    // Random: mostly small frames, ridge-like content, occasional wide spacing.
    for (int f = 0; pixels_sent < 1650; f++) begin
      ws = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(1, 8);
      w = 2 * ws + 1 + $urandom_range(0, 10);
      h = 2 * ws + 1 + $urandom_range(0, 6);
      if ($urandom_range(0, 19) == 0) w = 2 * ws;   // occasionally too narrow
      mode = pix_mode_e'($urandom_range(0, 3));
      if (f == 3) holdoff_req = 1'b1;   // block fills while the sender keeps going
      run_frames(ws, w, h, $urandom_range(1, 2), mode);
    end

    drain();
    $display("Covered %0d frames, %0d pixels, %0d results checked.",
             frames_run, pixels_sent, results_seen);
    $display("Spacings 0..15, widths and heights 0..4095, flat, line and noise images.");
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
